// ----- hdl/region_conflict_dispatcher_macros.svh -----
// Assertion macros for the region conflict dispatcher modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef REGION_CONFLICT_DISPATCHER_MACROS_SVH
`define REGION_CONFLICT_DISPATCHER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcd assertion failed");
// Next-cycle implication, disabled during reset.
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcd assertion failed");
`else
`define RCD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/rcd_pkg.sv -----
// Package of the region conflict dispatcher: beat types, status codes,
// controller command and status structs, parameter defaults. No dependencies.
`default_nettype none
package rcd_pkg;

  localparam int NUM_WORKERS_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;

  localparam logic [4:0] ACTIVE_RESET = 5'd16;

  localparam logic OP_DISPATCH = 1'b0;
  localparam logic OP_FREE     = 1'b1;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_NO_IDLE   = 3'd1;
  localparam logic [2:0] ST_CONFLICT  = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  typedef struct packed {
    logic        op;
    logic [4:0]  worker_id;
    logic [15:0] box_x_lo;
    logic [15:0] box_y_lo;
    logic [15:0] box_x_hi;
    logic [15:0] box_y_hi;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] granted_worker;
    logic [4:0] busy_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } rcd_cmd_t;

  typedef struct packed {
    logic scan_done;
  } rcd_sts_t;

endpackage
`default_nettype wire

// ----- hdl/rcd_ctrl.sv -----
// Controller of the region conflict dispatcher: accept, scan, finish.
// Depends on rcd_pkg and the assertion macro header.
`default_nettype none
`include "region_conflict_dispatcher_macros.svh"
module rcd_ctrl
  import rcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  rcd_sts_t sts,
  output logic     busy,
  output rcd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `RCD_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !cmd.finish)
  `RCD_ASSERT_NEXT(a_finish_idle, clk, rst_n, cmd.finish, !busy)
  `RCD_ASSERT_SAME(a_cmd_excl, clk, rst_n, cmd.finish || cmd.scan, !cmd.load && busy)

endmodule
`default_nettype wire

// ----- hdl/rcd_datapath.sv -----
// Datapath of the region conflict dispatcher: worker table, region memory,
// scan accumulators and the result register. Depends on rcd_pkg.
`default_nettype none
module rcd_datapath
  import rcd_pkg::*;
#(
  parameter int NUM_WORKERS = NUM_WORKERS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata,
  input  in_item_t  in_item,
  input  rcd_cmd_t  cmd,
  output rcd_sts_t  sts,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CNT_W = $clog2(NUM_WORKERS + 1);
  localparam int AW    = CNT_W + 5;
  localparam int REG_W = 4 * COORD_BITS;

  logic [4:0]             active_r;
  logic [NUM_WORKERS-1:0] busy_r;
  logic [REG_W-1:0]       region_mem [NUM_WORKERS];

  logic                  op_r, bad_r, req_empty_r;
  logic [COORD_BITS-1:0] xlo_r, ylo_r, xhi_r, yhi_r;
  logic [CNT_W-1:0]      rd_idx_r, cnt_r;
  logic                  data_vld_r;
  logic [IDX_W-1:0]      data_idx_r;
  logic [REG_W-1:0]      rd_data_r;
  logic                  found_r, clash_r;
  logic [IDX_W-1:0]      pick_r;
  logic                  out_vld_r;
  out_item_t             out_r;

  // Effective active count: values above the table size saturate.
  logic [AW-1:0]    act_w, n_w, id_w;
  logic [CNT_W-1:0] n_eff;
  logic             id_ok;
  logic [IDX_W+4:0] id_m1;

  assign act_w = AW'(active_r);
  assign n_w   = (act_w > AW'(NUM_WORKERS)) ? AW'(NUM_WORKERS) : act_w;
  assign n_eff = n_w[CNT_W-1:0];
  assign id_w  = AW'(in_item.worker_id);
  assign id_ok = (id_w != '0) && (id_w <= n_w);
  assign id_m1 = (IDX_W + 5)'(in_item.worker_id) - (IDX_W + 5)'(1);

  logic issue;
  assign issue = cmd.scan && (rd_idx_r < n_eff);
  assign sts.scan_done = (rd_idx_r == n_eff) && !data_vld_r;

  // Stored box lanes, x_lo lowest.
  logic [COORD_BITS-1:0] s_xlo, s_ylo, s_xhi, s_yhi;
  logic                  s_empty, hit, entry_busy;
  assign s_xlo = rd_data_r[COORD_BITS-1:0];
  assign s_ylo = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign s_xhi = rd_data_r[3*COORD_BITS-1:2*COORD_BITS];
  assign s_yhi = rd_data_r[4*COORD_BITS-1:3*COORD_BITS];
  assign s_empty = (s_xlo > s_xhi) || (s_ylo > s_yhi);
  assign hit = !req_empty_r && !s_empty &&
               !((xlo_r > s_xhi) || (xhi_r < s_xlo) || (ylo_r > s_yhi) || (yhi_r < s_ylo));
  assign entry_busy = busy_r[data_idx_r];

  logic grant;
  assign grant = (op_r == OP_DISPATCH) && found_r && !clash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (cmd.load && (in_item.op == OP_FREE) && id_ok) begin
      busy_r[id_m1[IDX_W-1:0]] <= 1'b0;
    end else if (cmd.finish && grant) begin
      busy_r[pick_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= region_mem[rd_idx_r[IDX_W-1:0]];
    end
    if (cmd.finish && grant) begin
      region_mem[pick_r] <= {yhi_r, xhi_r, ylo_r, xlo_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_item.op;
      bad_r       <= !id_ok;
      xlo_r       <= in_item.box_x_lo[COORD_BITS-1:0];
      ylo_r       <= in_item.box_y_lo[COORD_BITS-1:0];
      xhi_r       <= in_item.box_x_hi[COORD_BITS-1:0];
      yhi_r       <= in_item.box_y_hi[COORD_BITS-1:0];
      req_empty_r <= (in_item.box_x_lo[COORD_BITS-1:0] > in_item.box_x_hi[COORD_BITS-1:0]) ||
                     (in_item.box_y_lo[COORD_BITS-1:0] > in_item.box_y_hi[COORD_BITS-1:0]);
    end
  end

  // Accumulate runs in the cycle after each read issue, behind the registered read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_vld_r <= 1'b0;
      rd_idx_r   <= '0;
      found_r    <= 1'b0;
      clash_r    <= 1'b0;
      cnt_r      <= '0;
    end else if (cmd.load) begin
      data_vld_r <= 1'b0;
      rd_idx_r   <= '0;
      found_r    <= 1'b0;
      clash_r    <= 1'b0;
      cnt_r      <= '0;
    end else if (cmd.scan) begin
      data_vld_r <= issue;
      if (issue) begin
        rd_idx_r   <= rd_idx_r + CNT_W'(1);
        data_idx_r <= rd_idx_r[IDX_W-1:0];
      end
      if (data_vld_r) begin
        if (!entry_busy) begin
          if (!found_r) begin
            found_r <= 1'b1;
            pick_r  <= data_idx_r;
          end
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (hit) begin
            clash_r <= 1'b1;
          end
        end
      end
    end
  end

  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W+4:0] cnt_w;
  logic [IDX_W+4:0] gnt_w;
  logic [2:0]       status_nxt;

  assign cnt_after = grant ? cnt_r + CNT_W'(1) : cnt_r;
  assign cnt_w     = (CNT_W + 5)'(cnt_after);
  assign gnt_w     = (IDX_W + 5)'(pick_r) + (IDX_W + 5)'(1);

  always_comb begin
    if (op_r == OP_FREE) begin
      status_nxt = bad_r ? ST_BAD_INDEX : ST_FREED;
    end else if (!found_r) begin
      status_nxt = ST_NO_IDLE;
    end else if (clash_r) begin
      status_nxt = ST_CONFLICT;
    end else begin
      status_nxt = ST_GRANTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.status         <= status_nxt;
      out_r.granted_worker <= grant ? gnt_w[4:0] : 5'd0;
      out_r.busy_count     <= cnt_w[4:0];
    end
  end

  assign out_strobe = out_vld_r;
  assign out_item   = out_r;

endmodule
`default_nettype wire

// ----- hdl/region_conflict_dispatcher.sv -----
// Region conflict dispatcher, top level. A request passes from accept through
// the scan and done states before the next accept can be taken, busy being
// high meanwhile; the scan makes one region memory read per active worker.
// The result strobe is high in the first cycle with busy low, at the edge
// that may take the next beat; results cannot stall.
// Synchronous active-low reset: all workers idle, active count 16.
`default_nettype none
module region_conflict_dispatcher
  import rcd_pkg::*;
#(
  parameter int NUM_WORKERS = NUM_WORKERS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_item
);

  rcd_cmd_t cmd;
  rcd_sts_t sts;

  rcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  rcd_datapath #(
    .NUM_WORKERS (NUM_WORKERS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

// ----- bench/dispatch_checker.sv -----
// Checker for the region conflict dispatcher: follows request, result and register beats,
// predicts each outcome from its own worker table and compares it field by field.
// Depends on rcd_pkg for the beat types and status codes.
`timescale 1ns / 100ps
module dispatch_checker
  import rcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_item,
  input  logic       out_strobe,
  input  out_item_t  out_item,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [15:0] xlo;
    logic [15:0] ylo;
    logic [15:0] xhi;
    logic [15:0] yhi;
  } region_t;

  logic      busy_map [NUM_WORKERS_DEF];
  region_t   regions [NUM_WORKERS_DEF];
  logic [4:0] active_cfg;
  out_item_t expected_outcomes [$];
  out_item_t want;

  function automatic bit box_void(region_t r);
    return (r.xlo > r.xhi) || (r.ylo > r.yhi);
  endfunction

  function automatic bit overlaps(region_t a, region_t b);
    if (box_void(a) || box_void(b)) return 1'b0;
    return !(a.xlo > b.xhi || a.xhi < b.xlo || a.ylo > b.yhi || a.yhi < b.ylo);
  endfunction

  // Applies one request to the worker table and returns the outcome it must produce.
  // COORD_BITS is the full 16 here, so the box corners are taken whole.
  function automatic out_item_t dispatch_outcome(in_item_t req);
    out_item_t res;
    region_t   box;
    int        n;
    int        pick;
    int        count;
    bit        clash;
    n     = (active_cfg > NUM_WORKERS_DEF) ? NUM_WORKERS_DEF : int'(active_cfg);
    res   = '0;
    pick  = 0;
    count = 0;
    clash = 1'b0;
    if (req.op == OP_FREE) begin
      if (req.worker_id == 0 || req.worker_id > n) begin
        res.status = ST_BAD_INDEX;
      end else begin
        busy_map[req.worker_id - 1] = 1'b0;
        res.status = ST_FREED;
      end
    end else begin
      box = '{req.box_x_lo, req.box_y_lo, req.box_x_hi, req.box_y_hi};
      for (int k = 0; k < n; k++) begin
        if (!busy_map[k]) begin
          if (pick == 0) pick = k + 1;
        end else if (overlaps(regions[k], box)) begin
          clash = 1'b1;
        end
      end
      // An exhausted table is reported ahead of any overlap.
      if (pick == 0) begin
        res.status = ST_NO_IDLE;
      end else if (clash) begin
        res.status = ST_CONFLICT;
      end else begin
        regions[pick - 1]  = box;
        busy_map[pick - 1] = 1'b1;
        res.granted_worker = 5'(pick);
        res.status         = ST_GRANTED;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (busy_map[k]) count++;
    end
    res.busy_count = 5'(count);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_WORKERS_DEF; k++) begin
        busy_map[k] = 1'b0;
        regions[k]  = '0;
      end
      active_cfg = ACTIVE_RESET;
      expected_outcomes.delete();
    end else begin
      if (out_strobe) begin
        if (expected_outcomes.size() == 0) begin
          $error("result beat with no request pending: status %0d worker %0d busy %0d",
                 out_item.status, out_item.granted_worker, out_item.busy_count);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            mismatches++;
          end
          if (out_item.granted_worker !== want.granted_worker) begin
            $error("granted_worker: expected %0d, got %0d",
                   want.granted_worker, out_item.granted_worker);
            mismatches++;
          end
          if (out_item.busy_count !== want.busy_count) begin
            $error("busy_count: expected %0d, got %0d", want.busy_count, out_item.busy_count);
            mismatches++;
          end
        end
      end
      if (cfg_we) active_cfg = cfg_wdata;
      if (start && !busy) begin
        expected_outcomes.insert(expected_outcomes.size(), dispatch_outcome(in_item));
      end
    end
    // Published after the edge so the stimulus side reads a settled count.
    outstanding <= expected_outcomes.size();
  end

endmodule

// ----- bench/tb_region_conflict_dispatcher.sv -----
// Top of the region conflict dispatcher bench: clock, reset, request and register stimulus.
// Depends on rcd_pkg, region_conflict_dispatcher and dispatch_checker.
`timescale 1ns / 100ps
module tb_region_conflict_dispatcher;
  import rcd_pkg::*;

  localparam int   ITEMS_PER_LEG  = 225;
  localparam int   WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_strobe;
  out_item_t  out_item;
  int         mismatches;
  int         outstanding;
  int         idle_cycles = 0;
  int         act_n = 16;

  always #10 clk = ~clk;

  region_conflict_dispatcher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  dispatch_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Any accepted beat, request or result, resets the hang counter.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t free_req(logic [4:0] id);
    in_item_t it;
    it = '0;
    it.op = OP_FREE;
    it.worker_id = id;
    return it;
  endfunction

  function automatic in_item_t box_req(logic [15:0] xlo, logic [15:0] ylo,
                                       logic [15:0] xhi, logic [15:0] yhi);
    in_item_t it;
    it = '0;
    it.op = OP_DISPATCH;
    it = '{OP_DISPATCH, 5'd0, xlo, ylo, xhi, yhi};
    return it;
  endfunction

  // Mostly frees of live workers and boxes of random scale; a tenth is raw noise.
  function automatic in_item_t random_req();
    in_item_t it;
    int lo_x, lo_y, hi_x, hi_y;
    it = in_item_t'(70'({$urandom, $urandom, $urandom}));
    if ($urandom_range(0, 9) == 0) return it;
    if ($urandom_range(0, 99) < 45) begin
      it.op = OP_FREE;
      if (act_n > 0 && $urandom_range(0, 9) != 0) it.worker_id = 5'($urandom_range(1, act_n));
    end else begin
      it.op = OP_DISPATCH;
      lo_x = $urandom_range(0, 65535);
      lo_y = $urandom_range(0, 65535);
      hi_x = lo_x + $urandom_range(0, (1 << $urandom_range(0, 15)) - 1);
      hi_y = lo_y + $urandom_range(0, (1 << $urandom_range(0, 15)) - 1);
      if (hi_x > 65535) hi_x = 65535;
      if (hi_y > 65535) hi_y = 65535;
      it.box_x_lo = 16'(lo_x);
      it.box_y_lo = 16'(lo_y);
      it.box_x_hi = 16'(hi_x);
      it.box_y_hi = 16'(hi_y);
      if ($urandom_range(0, 9) == 0) begin
        it.box_x_lo = 16'(hi_x);
        it.box_x_hi = 16'(lo_x);
      end else if ($urandom_range(0, 9) == 0) begin
        it.box_y_lo = 16'(hi_y);
        it.box_y_hi = 16'(lo_y);
      end
    end
    return it;
  endfunction

  // Leaves start high on return so back-to-back beats need no extra edge.
  task automatic send(in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_active(logic [4:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    act_n = (value > 16) ? 16 : int'(value);
  endtask

  initial begin
    logic [4:0] leg_cfg [8];
    bit quiet;
    leg_cfg = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd9, 5'd17, 5'd0, 5'd16};
    leg_cfg[6] = 5'($urandom_range(2, 15));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bad indexes, freeing an idle worker, empty boxes, touching corners.
    send(free_req(5'd0));
    send(free_req(5'd31));
    rest(3);
    send(free_req(5'd17));
    send(free_req(5'd1));
    send(box_req(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send(box_req(16'd10, 16'd10, 16'd20, 16'd20));
    rest(1);
    send(box_req(16'd5, 16'h0000, 16'd4, 16'hFFFF));
    send(box_req(16'h0000, 16'd9, 16'hFFFF, 16'd8));
    send(free_req(5'd1));
    rest(6);
    send(box_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(box_req(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send(box_req(16'h0000, 16'h0000, 16'hFFFE, 16'hFFFE));
    send(box_req(16'h0001, 16'h0001, 16'hFFFE, 16'hFFFE));
    send(free_req(5'd16));
    send('{OP_DISPATCH, 5'd31, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    // Workers past the active count keep their state while hidden.
    write_active(5'd1);
    send(box_req(16'd100, 16'd100, 16'd200, 16'd200));
    send(free_req(5'd2));
    send(free_req(5'd1));
    send(box_req(16'd3, 16'd3, 16'd2, 16'd2));
    write_active(5'd0);
    send(box_req(16'd0, 16'd0, 16'd1, 16'd1));
    send(free_req(5'd1));
    write_active(5'd31);
    send(box_req(16'd300, 16'd300, 16'd400, 16'd400));
    send(free_req(5'd16));
    send(free_req(5'd17));

    for (int leg = 0; leg < 8; leg++) begin
      write_active(leg_cfg[leg]);
      quiet = (leg == 7);
      for (int i = 0; i < ITEMS_PER_LEG; i++) begin
        send(random_req());
        if (!quiet && $urandom_range(0, 149) == 0) begin
          drain();
        end else if (!quiet && (i % 60) < 40 && $urandom_range(0, 2) == 0) begin
          rest($urandom_range(1, 7));
        end
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
